// File: hdl/bpa_pkg.sv
// shared types, constants and helpers for the bitmap page allocator
package bpa_pkg;

    localparam int WORD_BITS     = 64;
    localparam int WORD_SH       = 6;
    localparam int NUM_PAGES_DEF = 1024;
    localparam int IDX_W         = 10;
    localparam int CNT_W         = 11;
    localparam int LIMIT_MAX     = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(1024);

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [WORD_SH-1:0]   bitpos_t;

    typedef enum logic {
        REQ_ACQUIRE = 1'b0,
        REQ_RELEASE = 1'b1
    } req_kind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_BAD_RELEASE = 2'd2
    } status_t;

    typedef struct packed {
        req_kind_t        req_type;
        logic [IDX_W-1:0] page_index;
    } req_t;

    typedef struct packed {
        status_t          status;
        logic [IDX_W-1:0] granted_page;
        logic [CNT_W-1:0] used_pages;
    } rsp_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    scan;
        logic    rel;
        logic    emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic    clear_last;
        logic    acq_full;
        logic    is_release;
        logic    scan_done;
        logic    out_free;
    } dp_sts_t;

    typedef struct packed {
        logic    found;
        bitpos_t pos;
    } free_bit_t;

    // lowest clear bit of a bitmap word
    function automatic free_bit_t first_free(input word_t w);
        free_bit_t r;
        r.found = 1'b0;
        r.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.pos   = bitpos_t'(i);
            end
        end
        return r;
    endfunction

endpackage

// File: hdl/bitmap_page_allocator.sv
// top level of the first-fit bitmap page allocator
// After reset the bitmap is cleared one 64-bit word per cycle, so s_ready stays low until
// the last word is cleared; page_limit writes are taken at any time. Requests are served
// one at a time, each giving one result transfer. A release goes through a word read, a
// check and write, and the result. An acquire at a full count goes straight to the result;
// otherwise the scan reads one bitmap word per cycle from word 0 until the first free page
// below the limit, or until the limit or the last word is reached. The result sits in an
// output register, so the next request is taken while it waits.
module bitmap_page_allocator #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bpa_pkg::req_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bpa_pkg::rsp_t               m_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bpa_pkg::CNT_W-1:0]   cfg_wdata
);

    bpa_pkg::ctl_cmd_t cmd;
    bpa_pkg::dp_sts_t  sts;

    assign cfg_ready = 1'b1;

    bpa_ctl u_ctl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bpa_dp #(
        .NUM_PAGES (NUM_PAGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_wdata (cfg_wdata),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// File: hdl/bpa_ctl.sv
// request sequencer for the bitmap page allocator
module bpa_ctl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  bpa_pkg::dp_sts_t  sts,
    output bpa_pkg::ctl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_REL,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load = 1'b1;
                    if (sts.is_release) begin
                        state_next = S_REL;
                    end else if (sts.acq_full) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_DONE;
                end
            end
            S_REL: begin
                cmd.rel    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/bpa_dp.sv
// bitmap memory, used-page count, limit register and result registers
module bpa_dp #(
    parameter int NUM_PAGES = bpa_pkg::NUM_PAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bpa_pkg::req_t     s_data,
    input  logic              cfg_valid,
    input  logic [bpa_pkg::CNT_W-1:0] cfg_wdata,
    output logic              m_valid,
    input  logic              m_ready,
    output bpa_pkg::rsp_t     m_data,
    input  bpa_pkg::ctl_cmd_t cmd,
    output bpa_pkg::dp_sts_t  sts
);

    localparam int NUM_WORDS = (NUM_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
    localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PAGE_W    = WIDX_W + bpa_pkg::WORD_SH;
    localparam int CAP       = (NUM_PAGES < bpa_pkg::LIMIT_MAX) ? NUM_PAGES
                                                                : bpa_pkg::LIMIT_MAX;
    localparam int CW        = bpa_pkg::CNT_W;

    bpa_pkg::word_t mem [NUM_WORDS];

    logic [CW-1:0]          limit_reg;
    logic [CW-1:0]          count_reg;
    logic [WIDX_W-1:0]      clr_w_reg;
    logic [WIDX_W-1:0]      chk_w_reg;
    logic [bpa_pkg::IDX_W-1:0] idx_reg;
    bpa_pkg::word_t         rd_data_reg;
    bpa_pkg::rsp_t          res_reg;
    bpa_pkg::rsp_t          out_reg;
    logic                   m_valid_reg;

    logic [CW-1:0]          eff;
    logic [WIDX_W-1:0]      rel_word;
    logic [WIDX_W-1:0]      rd_addr;
    bpa_pkg::free_bit_t     fb;
    logic [PAGE_W-1:0]      hit_page;
    logic                   scan_hit;
    logic                   scan_end;
    logic                   rel_bad;
    logic                   acq_full;

    assign eff      = (limit_reg > CW'(CAP)) ? CW'(CAP) : limit_reg;
    assign rel_word = WIDX_W'(32'(s_data.page_index) >> bpa_pkg::WORD_SH);
    assign acq_full = (count_reg >= eff);

    assign fb       = bpa_pkg::first_free(rd_data_reg);
    assign hit_page = {chk_w_reg, fb.pos};
    assign scan_hit = fb.found && (32'(hit_page) < 32'(eff));
    assign scan_end = !scan_hit &&
                      (fb.found || (32'(chk_w_reg) == NUM_WORDS - 1) ||
                       (((32'(chk_w_reg) + 1) << bpa_pkg::WORD_SH) >= 32'(eff)));

    assign rel_bad  = (CW'(idx_reg) >= eff) ||
                      !rd_data_reg[bpa_pkg::bitpos_t'(idx_reg)];

    always_comb begin
        if (cmd.scan) begin
            rd_addr = chk_w_reg + WIDX_W'(1);
        end else if (s_data.req_type == bpa_pkg::REQ_RELEASE) begin
            rd_addr = rel_word;
        end else begin
            rd_addr = '0;
        end
    end

    assign sts.clear_last = (32'(clr_w_reg) == NUM_WORDS - 1);
    assign sts.acq_full   = acq_full;
    assign sts.is_release = (s_data.req_type == bpa_pkg::REQ_RELEASE);
    assign sts.scan_done  = scan_hit || scan_end;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (cmd.clear) begin
            mem[clr_w_reg] <= '0;
        end else if (cmd.scan && scan_hit) begin
            mem[chk_w_reg] <= rd_data_reg | (bpa_pkg::word_t'(1) << fb.pos);
        end else if (cmd.rel && !rel_bad) begin
            mem[WIDX_W'(32'(idx_reg) >> bpa_pkg::WORD_SH)] <=
                rd_data_reg & ~(bpa_pkg::word_t'(1) << bpa_pkg::bitpos_t'(idx_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg   <= bpa_pkg::LIMIT_RESET;
            count_reg   <= '0;
            clr_w_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                limit_reg <= cfg_wdata;
            end
            if (cmd.clear) begin
                clr_w_reg <= clr_w_reg + WIDX_W'(1);
            end
            if (cmd.scan && scan_hit) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.rel && !rel_bad && count_reg != '0) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg   <= s_data.page_index;
            chk_w_reg <= '0;
            if (s_data.req_type == bpa_pkg::REQ_ACQUIRE && acq_full) begin
                res_reg.status       <= bpa_pkg::ST_FULL;
                res_reg.granted_page <= '0;
                res_reg.used_pages   <= count_reg;
            end
        end
        if (cmd.scan) begin
            chk_w_reg <= chk_w_reg + WIDX_W'(1);
            if (scan_hit) begin
                res_reg.status       <= bpa_pkg::ST_OK;
                res_reg.granted_page <= bpa_pkg::IDX_W'(hit_page);
                res_reg.used_pages   <= count_reg + CW'(1);
            end else begin
                res_reg.status       <= bpa_pkg::ST_FULL;
                res_reg.granted_page <= '0;
                res_reg.used_pages   <= count_reg;
            end
        end
        if (cmd.rel) begin
            res_reg.granted_page <= '0;
            if (rel_bad) begin
                res_reg.status     <= bpa_pkg::ST_BAD_RELEASE;
                res_reg.used_pages <= count_reg;
            end else begin
                res_reg.status     <= bpa_pkg::ST_OK;
                res_reg.used_pages <= (count_reg != '0) ? count_reg - CW'(1) : count_reg;
            end
        end
        if (cmd.emit) begin
            out_reg <= res_reg;
        end
    end

endmodule

// File: dv/tb.sv
// self-checking testbench for the bitmap page allocator
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;

    class page_alloc_board;
        logic [bpa_pkg::NUM_PAGES_DEF-1:0] used_map;
        int unsigned                       used_cnt;
        logic [bpa_pkg::CNT_W-1:0]         limit_reg;
        bpa_pkg::rsp_t                     awaited_rsp[$];
        int                                errors;

        function new();
            used_map  = '0;
            used_cnt  = 0;
            limit_reg = bpa_pkg::LIMIT_RESET;
            errors    = 0;
        endfunction

        function int unsigned eff_limit();
            return (limit_reg > bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES_DEF)) ?
                   bpa_pkg::NUM_PAGES_DEF : limit_reg;
        endfunction

        function void set_limit(logic [bpa_pkg::CNT_W-1:0] v);
            limit_reg = v;
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction

        // first-fit grant or release, then queue the response it gives
        function void apply_request(bpa_pkg::req_t r);
            bpa_pkg::rsp_t e;
            int unsigned   lim;
            bit            found;
            lim            = eff_limit();
            e.status       = bpa_pkg::ST_OK;
            e.granted_page = '0;
            found          = 1'b0;
            if (r.req_type == bpa_pkg::REQ_ACQUIRE) begin
                if (used_cnt < lim) begin
                    for (int p = 0; p < lim && !found; p++) begin
                        if (!used_map[p]) begin
                            used_map[p]    = 1'b1;
                            used_cnt++;
                            e.granted_page = bpa_pkg::IDX_W'(p);
                            found          = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    e.status = bpa_pkg::ST_FULL;
                end
            end else begin
                if (r.page_index >= lim || !used_map[r.page_index]) begin
                    e.status = bpa_pkg::ST_BAD_RELEASE;
                end else begin
                    used_map[r.page_index] = 1'b0;
                    if (used_cnt > 0) begin
                        used_cnt--;
                    end
                end
            end
            e.used_pages = bpa_pkg::CNT_W'(used_cnt);
            awaited_rsp.push_back(e);
        endfunction

        function void check_response(bpa_pkg::rsp_t got);
            bpa_pkg::rsp_t e;
            if (awaited_rsp.size() == 0) begin
                errors++;
                $display("%0t: response with none awaited: status %0d page %0d used %0d",
                         $time, got.status, got.granted_page, got.used_pages);
                return;
            end
            e = awaited_rsp.pop_front();
            if (got.status !== e.status) begin
                errors++;
                $display("%0t: status expected %0d got %0d", $time, e.status, got.status);
            end
            if (got.granted_page !== e.granted_page) begin
                errors++;
                $display("%0t: granted_page expected %0d got %0d",
                         $time, e.granted_page, got.granted_page);
            end
            if (got.used_pages !== e.used_pages) begin
                errors++;
                $display("%0t: used_pages expected %0d got %0d",
                         $time, e.used_pages, got.used_pages);
            end
        endfunction

        // mostly a used page below the limit, otherwise any index
        function logic [bpa_pkg::IDX_W-1:0] release_candidate();
            int unsigned lim;
            int unsigned start;
            int unsigned p;
            lim = eff_limit();
            if (used_cnt != 0 && lim != 0 && $urandom_range(99) < 80) begin
                start = $urandom_range(lim - 1);
                for (int k = 0; k < lim; k++) begin
                    p = (start + k) % lim;
                    if (used_map[p]) begin
                        return bpa_pkg::IDX_W'(p);
                    end
                end
            end
            return bpa_pkg::IDX_W'($urandom);
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    bpa_pkg::req_t             s_data;
    logic                      m_valid;
    logic                      m_ready;
    bpa_pkg::rsp_t             m_data;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [bpa_pkg::CNT_W-1:0] cfg_wdata;

    page_alloc_board sb;
    int              rx_stall_pct;
    int              hold_gen;
    int              hold_seen;
    int              hold_left;
    int              cycle_cnt;

    bitmap_page_allocator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
    end

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // result side ready, with a counted long hold-off when asked
    always @(negedge aclk) begin
        if (hold_seen != hold_gen) begin
            hold_seen = hold_gen;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (m_valid === 1'b1 && m_ready) begin
            sb.check_response(m_data);
        end
    end

    task automatic send_req(input bpa_pkg::req_t r, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= r;
        do @(posedge aclk); while (!s_ready);
        sb.apply_request(r);
    endtask

    task automatic send_one(input bpa_pkg::req_kind_t kind,
                            input logic [bpa_pkg::IDX_W-1:0] idx);
        bpa_pkg::req_t r;
        r.req_type   = kind;
        r.page_index = idx;
        send_req(r, 0);
    endtask

    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_limit(input logic [bpa_pkg::CNT_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_limit(v);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int acq_pct, input int tx_idle_pct);
        bpa_pkg::req_t r;
        repeat (n) begin
            if ($urandom_range(99) < acq_pct) begin
                r.req_type   = bpa_pkg::REQ_ACQUIRE;
                r.page_index = bpa_pkg::IDX_W'($urandom);
            end else begin
                r.req_type   = bpa_pkg::REQ_RELEASE;
                r.page_index = sb.release_candidate();
            end
            send_req(r, tx_idle_pct);
        end
    endtask

    initial begin
        int guard;
        sb           = new();
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_wdata    = '0;
        rx_stall_pct = 0;
        hold_gen     = 0;
        guard        = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: small limit, full, bad releases, limit edges
        write_limit(bpa_pkg::CNT_W'(3));
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h3FF);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h2AA);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h155);
        send_one(bpa_pkg::REQ_RELEASE, 10'd1);
        send_one(bpa_pkg::REQ_RELEASE, 10'd1);
        send_one(bpa_pkg::REQ_RELEASE, 10'd3);
        send_one(bpa_pkg::REQ_RELEASE, 10'h3FF);
        send_one(bpa_pkg::REQ_RELEASE, 10'h2AA);
        send_one(bpa_pkg::REQ_RELEASE, 10'h155);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        wait_drain();
        write_limit(bpa_pkg::CNT_W'(0));
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        send_one(bpa_pkg::REQ_RELEASE, 10'd0);
        wait_drain();
        write_limit(bpa_pkg::CNT_W'(bpa_pkg::LIMIT_MAX));
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        send_one(bpa_pkg::REQ_RELEASE, 10'd2);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h3FF);
        send_one(bpa_pkg::REQ_RELEASE, 10'h3FF);
        wait_drain();
        write_limit(bpa_pkg::CNT_W'(2));
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        send_one(bpa_pkg::REQ_RELEASE, 10'd3);
        send_one(bpa_pkg::REQ_RELEASE, 10'd0);
        send_one(bpa_pkg::REQ_ACQUIRE, 10'h000);
        wait_drain();

        rx_stall_pct = 0;
        write_limit(bpa_pkg::CNT_W'(bpa_pkg::NUM_PAGES_DEF));
        random_phase(160, 70, 0);
        wait_drain();

        write_limit(bpa_pkg::CNT_W'(70));
        random_phase(160, 55, 84);
        wait_drain();

        rx_stall_pct = 84;
        write_limit(bpa_pkg::CNT_W'(bpa_pkg::LIMIT_MAX));
        random_phase(160, 65, 0);
        wait_drain();

        rx_stall_pct = 16;
        write_limit(bpa_pkg::CNT_W'(0));
        random_phase(40, 50, 16);
        wait_drain();

        rx_stall_pct = 0;
        write_limit(bpa_pkg::CNT_W'(1));
        random_phase(40, 50, 0);
        wait_drain();

        // long result hold-off while requests keep coming
        write_limit(bpa_pkg::CNT_W'(130));
        @(posedge aclk);
        hold_gen = hold_gen + 1;
        random_phase(40, 60, 0);
        wait_drain();

        // fill every page below the limit, then push past full
        rx_stall_pct = 16;
        write_limit(bpa_pkg::CNT_W'(256));
        while (sb.used_cnt < sb.eff_limit() && guard < 600) begin
            random_phase(1, 97, 16);
            guard++;
        end
        random_phase(20, 97, 16);
        wait_drain();

        repeat (40) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/bpa_pkg.sv
hdl/bpa_ctl.sv
hdl/bpa_dp.sv
hdl/bitmap_page_allocator.sv
dv/tb.sv
